// ===== rtl/dlr_pkg.sv =====
package dlr_pkg;

  // Color channel width of a line and of a pixel
  localparam int unsigned COLOR_W = 24;

  // Item kinds carried on the input tuser bit
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Controller states
  typedef enum logic {
    ST_READY,
    ST_DIVIDE
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture a start request and set up the divider
    logic div_step;  // run one restoring divider iteration on both axes
    logic tick;      // emit one pixel and advance the line
    logic pop;       // downstream takes the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic steps_zero;  // endpoints of the offered request coincide
    logic div_last;    // current divider iteration is the final one
    logic out_full;    // output register holds a pixel not yet taken
  } stat_t;

endpackage

// ===== rtl/dlr_ctrl.sv =====
module dlr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  input  logic           op_i,
  input  logic           m_tready_i,
  output logic           s_tready_o,
  input  dlr_pkg::stat_t stat_i,
  output dlr_pkg::cmd_t  cmd_o
);
  import dlr_pkg::*;

  state_e state_q, state_d;
  logic   can_take;
  logic   accept;

  // Hold the state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READY;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register frees up when empty or when it is taken this cycle
  assign can_take = !stat_i.out_full || m_tready_i;

  // Decode requests and sequence the divider
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.pop    = m_tready_i;
    s_tready_o   = 1'b0;
    accept       = 1'b0;
    case (state_q)
      ST_READY: begin
        s_tready_o = can_take;
        accept     = s_tvalid_i && can_take;
        if (accept) begin
          if (op_i == OP_START) begin
            cmd_o.load = 1'b1;
            if (!stat_i.steps_zero) begin
              state_d = ST_DIVIDE;
            end
          end else begin
            cmd_o.tick = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_READY;
        end
      end
      default: begin
        state_d = ST_READY;
      end
    endcase
  end

  // No request is taken while the divider runs
  a_no_accept_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> !s_tready_o)
    else $error("request accepted during division");

  // A line of nonzero length always enters the divider
  a_load_enters_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && !stat_i.steps_zero) |=> (state_q == ST_DIVIDE))
    else $error("nonzero line skipped division");

  // The final iteration returns to accepting requests
  a_divide_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_step && stat_i.div_last) |=> (state_q == ST_READY))
    else $error("divider did not finish");

endmodule

// ===== rtl/dlr_datapath.sv =====
module dlr_datapath #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dlr_pkg::cmd_t               cmd_i,
  output dlr_pkg::stat_t              stat_o,
  input  logic [COORD_BITS-1:0]       start_x_i,
  input  logic [COORD_BITS-1:0]       start_y_i,
  input  logic [COORD_BITS-1:0]       end_x_i,
  input  logic [COORD_BITS-1:0]       end_y_i,
  input  logic [dlr_pkg::COLOR_W-1:0] line_color_i,
  output logic [COORD_BITS-1:0]       pixel_x_o,
  output logic [COORD_BITS-1:0]       pixel_y_o,
  output logic [dlr_pkg::COLOR_W-1:0] pixel_color_o,
  output logic                        draw_o,
  output logic                        done_o,
  output logic                        valid_o
);
  import dlr_pkg::*;

  localparam int unsigned POS_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned STEP_W = COORD_BITS + 1;
  localparam int unsigned QUOT_W = FRAC_BITS + 1;
  localparam int unsigned CNT_W  = $clog2(FRAC_BITS + 1);

  // Line state
  logic [POS_W-1:0]   pos_x_q, pos_y_q;
  logic [POS_W-1:0]   inc_x_q, inc_y_q;
  logic [STEP_W-1:0]  idx_q, total_q;
  logic [COLOR_W-1:0] color_q;
  logic               busy_q;

  // Divider state, one lane per axis
  logic [STEP_W-1:0]  rem_x_q, rem_y_q;
  logic [QUOT_W-1:0]  quot_x_q, quot_y_q;
  logic               neg_x_q, neg_y_q;
  logic [CNT_W-1:0]   cnt_q;

  // Output register
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [COLOR_W-1:0]    out_color_q;
  logic                  out_draw_q, out_done_q, out_valid_q;

  // Start request decode
  logic signed [STEP_W-1:0] dx, dy;
  logic [STEP_W-1:0]        ax, ay, steps_in;

  assign dx       = STEP_W'($signed(end_x_i)) - STEP_W'($signed(start_x_i));
  assign dy       = STEP_W'($signed(end_y_i)) - STEP_W'($signed(start_y_i));
  assign ax       = dx[STEP_W-1] ? STEP_W'(-dx) : STEP_W'(dx);
  assign ay       = dy[STEP_W-1] ? STEP_W'(-dy) : STEP_W'(dy);
  assign steps_in = (ax > ay) ? ax : ay;

  // Restoring divider iteration: compare, subtract, shift
  logic              ge_x, ge_y;
  logic [STEP_W-1:0] sub_x, sub_y;
  logic [QUOT_W-1:0] quot_x_d, quot_y_d;
  logic [POS_W-1:0]  mag_x, mag_y, inc_x_d, inc_y_d;

  assign ge_x     = rem_x_q >= total_q;
  assign ge_y     = rem_y_q >= total_q;
  assign sub_x    = ge_x ? rem_x_q - total_q : rem_x_q;
  assign sub_y    = ge_y ? rem_y_q - total_q : rem_y_q;
  assign quot_x_d = {quot_x_q[QUOT_W-2:0], ge_x};
  assign quot_y_d = {quot_y_q[QUOT_W-2:0], ge_y};
  assign mag_x    = POS_W'(quot_x_d);
  assign mag_y    = POS_W'(quot_y_d);
  assign inc_x_d  = neg_x_q ? POS_W'(-mag_x) : mag_x;
  assign inc_y_d  = neg_y_q ? POS_W'(-mag_y) : mag_y;

  // Truncate positions toward zero: floor, then bump negatives with a fraction
  logic [STEP_W-1:0] int_x, int_y;

  assign int_x = pos_x_q[POS_W-1:FRAC_BITS]
               + STEP_W'(pos_x_q[POS_W-1] && (|pos_x_q[FRAC_BITS-1:0]));
  assign int_y = pos_y_q[POS_W-1:FRAC_BITS]
               + STEP_W'(pos_y_q[POS_W-1] && (|pos_y_q[FRAC_BITS-1:0]));

  logic last_step;
  assign last_step = (idx_q == total_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(FRAC_BITS);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end else if (cmd_i.tick && busy_q && last_step) begin
        busy_q <= 1'b0;
      end
      if (cmd_i.tick) begin
        out_valid_q <= 1'b1;
      end else if (cmd_i.pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_x_q  <= {start_x_i[COORD_BITS-1], start_x_i, {FRAC_BITS{1'b0}}};
      pos_y_q  <= {start_y_i[COORD_BITS-1], start_y_i, {FRAC_BITS{1'b0}}};
      inc_x_q  <= '0;
      inc_y_q  <= '0;
      idx_q    <= '0;
      total_q  <= steps_in;
      color_q  <= line_color_i;
      rem_x_q  <= ax;
      rem_y_q  <= ay;
      quot_x_q <= '0;
      quot_y_q <= '0;
      neg_x_q  <= dx[STEP_W-1];
      neg_y_q  <= dy[STEP_W-1];
    end else if (cmd_i.div_step) begin
      rem_x_q  <= {sub_x[STEP_W-2:0], 1'b0};
      rem_y_q  <= {sub_y[STEP_W-2:0], 1'b0};
      quot_x_q <= quot_x_d;
      quot_y_q <= quot_y_d;
      if (cnt_q == '0) begin
        inc_x_q <= inc_x_d;
        inc_y_q <= inc_y_d;
      end
    end else if (cmd_i.tick && busy_q) begin
      pos_x_q <= pos_x_q + inc_x_q;
      pos_y_q <= pos_y_q + inc_y_q;
      idx_q   <= idx_q + STEP_W'(1);
    end

    // Emit the current pixel, or an idle marker
    if (cmd_i.tick) begin
      if (busy_q) begin
        out_x_q     <= int_x[COORD_BITS-1:0];
        out_y_q     <= int_y[COORD_BITS-1:0];
        out_color_q <= color_q;
        out_draw_q  <= (idx_q != '0) && (idx_q < total_q);
        out_done_q  <= last_step;
      end else begin
        out_x_q     <= '0;
        out_y_q     <= '0;
        out_color_q <= '0;
        out_draw_q  <= 1'b0;
        out_done_q  <= 1'b1;
      end
    end
  end

  assign stat_o.steps_zero = (steps_in == '0);
  assign stat_o.div_last   = (cnt_q == '0);
  assign stat_o.out_full   = out_valid_q;

  assign pixel_x_o     = out_x_q;
  assign pixel_y_o     = out_y_q;
  assign pixel_color_o = out_color_q;
  assign draw_o        = out_draw_q;
  assign done_o        = out_done_q;
  assign valid_o       = out_valid_q;

  // The step index never passes the step count of an active line
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= total_q))
    else $error("step index beyond step count");

  // Division only runs for a loaded line
  a_divide_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> busy_q)
    else $error("division without a line");

  // Every tick leaves a pixel in the output register
  a_tick_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick |=> out_valid_q)
    else $error("tick produced no pixel");

endmodule

// ===== rtl/dda_line_rasterizer.sv =====
// DDA line rasterizer. A start request (tuser = 0) loads two integer endpoints
// and a color; each tick request (tuser = 1) returns one pixel with the
// position truncated toward zero, tuser set for interior points to plot and
// tlast set on the final point of the line (or on a tick with no line active).
// Ticks are taken one per cycle while the output is taken and the divider is
// idle. A start is loaded, then runs the restoring divider that computes
// both per-axis increments side by side, one quotient bit a cycle;
// a zero-length line skips the divider. A start arriving mid-line abandons
// the current line.
module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // start_x, start_y, end_x, end_y, line_color (lowest bit up)
  input  logic [((4*COORD_BITS+dlr_pkg::COLOR_W+7)/8)*8-1:0] s_axis_tdata,
  // op
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // pixel_x, pixel_y, pixel_color (lowest bit up)
  output logic [((2*COORD_BITS+dlr_pkg::COLOR_W+7)/8)*8-1:0] m_axis_tdata,
  // draw
  output logic                      m_axis_tuser,
  // done_res
  output logic                      m_axis_tlast
);
  import dlr_pkg::*;

  localparam int unsigned OUT_W = ((2*COORD_BITS + COLOR_W + 7) / 8) * 8;

  cmd_t  cmd;
  stat_t stat;

  logic [COORD_BITS-1:0] pixel_x, pixel_y;
  logic [COLOR_W-1:0]    pixel_color;

  dlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .op_i       (s_axis_tuser),
    .m_tready_i (m_axis_tready),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dlr_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .start_x_i     (s_axis_tdata[COORD_BITS-1:0]),
    .start_y_i     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x_i       (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y_i       (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .line_color_i  (s_axis_tdata[4*COORD_BITS+COLOR_W-1:4*COORD_BITS]),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .draw_o        (m_axis_tuser),
    .done_o        (m_axis_tlast),
    .valid_o       (m_axis_tvalid)
  );

  // Pack the pixel, padding with zeros to whole bytes
  assign m_axis_tdata = OUT_W'({pixel_color, pixel_y, pixel_x});

endmodule

// ===== dv/tb_dda_line_rasterizer.sv =====
module tb_dda_line_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  import dlr_pkg::*;

  localparam int unsigned IN_W        = 72;
  localparam int unsigned OUT_W       = 48;
  localparam int          RANDOM_ITEMS = 500;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          DRAIN       = 32;
  localparam int          LONG_TICKS  = 200;

  // One pixel as it leaves the block
  typedef struct {
    logic [11:0]        x;
    logic [11:0]        y;
    logic [COLOR_W-1:0] color;
    logic               draw;
    logic               done;
  } pixel_t;

  // Tracks the line state and holds the pixels still owed by the block
  class RasterTracker;
    logic [28:0]        pos_x, pos_y, inc_x, inc_y;
    logic [12:0]        idx, total;
    logic [COLOR_W-1:0] color;
    bit                 busy;
    pixel_t             pending_pixels[$];
    int unsigned        errors;

    function new();
      pos_x = '0; pos_y = '0; inc_x = '0; inc_y = '0;
      idx = '0; total = '0; color = '0; busy = 0;
      errors = 0;
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    // Per-axis increment d/steps in Q12.16, truncated toward zero
    function logic [28:0] step_inc(int d, int steps);
      longint      q;
      logic [28:0] r;
      q = (longint'(d < 0 ? -d : d) << 16) / steps;
      r = q[28:0];
      if (d < 0) r = -r;
      return r;
    endfunction

    // Integer part of a position, truncated toward zero
    function logic [11:0] whole(logic [28:0] p);
      longint s;
      longint ip;
      s = $signed(p);
      ip = (s < 0) ? -((-s) >> 16) : (s >> 16);
      return ip[11:0];
    endfunction

    function void note_request(logic op, logic [IN_W-1:0] d);
      int     sx, sy, ex, ey, ax, ay, steps;
      pixel_t px;
      if (op == OP_START) begin
        sx = $signed(d[11:0]);
        sy = $signed(d[23:12]);
        ex = $signed(d[35:24]);
        ey = $signed(d[47:36]);
        ax = (ex - sx) < 0 ? sx - ex : ex - sx;
        ay = (ey - sy) < 0 ? sy - ey : ey - sy;
        steps = ax > ay ? ax : ay;
        pos_x = {d[11], d[11:0], 16'h0000};
        pos_y = {d[23], d[23:12], 16'h0000};
        total = steps[12:0];
        idx = '0;
        if (steps != 0) begin
          inc_x = step_inc(ex - sx, steps);
          inc_y = step_inc(ey - sy, steps);
        end else begin
          inc_x = '0;
          inc_y = '0;
        end
        color = d[71:48];
        busy = 1;
      end else if (!busy) begin
        px = '{x: '0, y: '0, color: '0, draw: 1'b0, done: 1'b1};
        pending_pixels.push_back(px);
      end else begin
        px.x = whole(pos_x);
        px.y = whole(pos_y);
        px.color = color;
        px.draw = (idx > 0) && (idx < total);
        px.done = (idx == total);
        pending_pixels.push_back(px);
        if (idx == total) busy = 0;
        pos_x = pos_x + inc_x;
        pos_y = pos_y + inc_y;
        idx = idx + 1'b1;
      end
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("[%0t] pixel mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
    endtask

    task check_pixel(logic [OUT_W-1:0] d, logic draw, logic done);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report("unexpected pixel", d[31:0], 32'h0);
      end else begin
        want = pending_pixels.pop_front();
        if (d[11:0] !== want.x) report("pixel_x", d[11:0], want.x);
        if (d[23:12] !== want.y) report("pixel_y", d[23:12], want.y);
        if (d[47:24] !== want.color) report("pixel_color", d[47:24], want.color);
        if (draw !== want.draw) report("draw", draw, want.draw);
        if (done !== want.done) report("done", done, want.done);
      end
    endtask
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic              s_axis_tuser  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;

  RasterTracker tracker = new();
  int           quiet_cycles = 0;
  int           sent_items = 0;
  int           burst_left = 0;
  bit           steady = 0;

  // Receiver stall pattern state
  int           pat_left = 0;
  int           pat_mode = 0;
  logic [7:0]   pat_mask = 8'hff;
  logic [2:0]   pat_phase = '0;

  dda_line_rasterizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Note accepted requests first, then check pixels taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_pixel(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stall the output side: always ready, a rotating mask, or coin flips
  always @(posedge clk_i) begin
    pat_phase <= pat_phase + 1'b1;
    if (pat_left == 0) begin
      pat_mode <= $urandom_range(0, 2);
      pat_mask <= 8'($urandom) | 8'h01;
      pat_left <= $urandom_range(16, 64);
    end else begin
      pat_left <= pat_left - 1;
    end
    case (pat_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= pat_mask[pat_phase];
      end
      default: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
    endcase
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [IN_W-1:0] pack_line(int sx, int sy, int ex, int ey,
                                                 logic [COLOR_W-1:0] color);
    logic [IN_W-1:0] d;
    d = {color, ey[11:0], ex[11:0], sy[11:0], sx[11:0]};
    return d;
  endfunction

  function automatic logic [IN_W-1:0] noise();
    return IN_W'({$urandom, $urandom, $urandom});
  endfunction

  function automatic int line_steps(int sx, int sy, int ex, int ey);
    int ax, ay;
    ax = ex > sx ? ex - sx : sx - ex;
    ay = ey > sy ? ey - sy : sy - ey;
    return ax > ay ? ax : ay;
  endfunction

  // Keep an endpoint in range by flipping the offset when it would overflow
  function automatic int offset_coord(int c, int d);
    if (c + d > 2047 || c + d < -2048) return c - d;
    return c + d;
  endfunction

  // Offer one request in bursts with gaps and wait until it is taken
  task automatic send_request(logic op, logic [IN_W-1:0] payload);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= payload;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
  endtask

  task automatic run_line(int sx, int sy, int ex, int ey, logic [COLOR_W-1:0] color,
                          int ticks);
    send_request(OP_START, pack_line(sx, sy, ex, ey, color));
    repeat (ticks) send_request(OP_TICK, noise());
  endtask

  // Hold off the sender until every owed pixel has come out
  task automatic drain_pixels();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int sx, sy, ex, ey, dx, dy, steps, ticks, pick, span;
    bit long_done;
    long_done = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tick with no line active
    send_request(OP_TICK, noise());
    // Zero-length line at a corner, then an idle tick
    run_line(-2048, 2047, -2048, 2047, 24'hffffff, 1);
    send_request(OP_TICK, '1);
    // Full-span diagonal, abandoned after a few steps by a new start
    run_line(-2048, -2048, 2047, 2047, 24'h000000, 3);
    run_line(2047, -2048, 2040, -2041, 24'ha5c35a, 8);
    // Shallow line with a negative y slope
    run_line(0, 0, 3, -1, 24'h5a3ca5, 4);
    drain_pixels();

    while (sent_items < RANDOM_ITEMS + 22) begin
      if ($urandom_range(0, 9) == 0) steady = ~steady;
      pick = $urandom_range(0, 99);
      sx = int'($urandom_range(0, 4095)) - 2048;
      sy = int'($urandom_range(0, 4095)) - 2048;
      if (!long_done && sent_items > 250) begin
        // One line of maximum length, followed over its first stretch
        run_line(2047, -2048, -2048, 2047, 24'($urandom), LONG_TICKS);
        long_done = 1;
        drain_pixels();
      end else if (pick < 80) begin
        span = ($urandom_range(0, 9) == 0) ? 300 : 12;
        dx = int'($urandom_range(0, 2 * span)) - span;
        dy = int'($urandom_range(0, 2 * span)) - span;
        ex = offset_coord(sx, dx);
        ey = offset_coord(sy, dy);
        steps = line_steps(sx, sy, ex, ey);
        ticks = ($urandom_range(0, 6) == 0) ? $urandom_range(0, steps) : steps + 1;
        if ($urandom_range(0, 9) == 0) ticks += $urandom_range(1, 2);
        run_line(sx, sy, ex, ey, 24'($urandom), ticks);
      end else if (pick < 90) begin
        send_request(OP_TICK, noise());
      end else begin
        ex = int'($urandom_range(0, 4095)) - 2048;
        ey = int'($urandom_range(0, 4095)) - 2048;
        run_line(sx, sy, ex, ey, 24'($urandom), $urandom_range(0, 4));
      end
      if (sent_items > 400 && sent_items < 420) drain_pixels();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
